/* sv/qcgg_pkg.sv */
`timescale 1ns / 1ps
package qcgg_pkg;

   localparam int NUM_LEGS_C = 4;
   localparam logic [9:0] COUNT_MAX = 10'd1023;

   // configuration register indexes
   localparam logic [1:0] REG_WINDOW_TICKS   = 2'd0;
   localparam logic [1:0] REG_LIFT_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_SPEED_DEADBAND = 2'd2;

   localparam logic [7:0] WINDOW_RESET   = 8'd36;
   localparam logic [7:0] LIFT_RESET     = 8'd40;
   localparam logic [4:0] DEADBAND_RESET = 5'd2;
   localparam logic [7:0] WINDOW_MIN     = 8'd2;

   // leg that swings in each window: FR, BL, FL, BR
   localparam logic [1:0] SWING_ORDER [4] = '{2'd0, 2'd2, 2'd1, 2'd3};

   // one tick handed from the front to the back
   typedef struct packed {
      logic              stand;
      logic signed [5:0] fwd;
      logic signed [5:0] lat;
      logic signed [5:0] turn;
      logic [7:0]        cyc;
      logic [7:0]        lift;
      logic [3:0]        flags;
      logic [3:0][9:0]   cnt;
      logic              placed;
      logic [1:0]        leg;
      logic [7:0]        k;
   } job_type;

   function automatic logic [5:0] abs6(input logic signed [5:0] v);
      abs6 = v[5] ? 6'(-v) : 6'(v);
   endfunction

endpackage

/* sv/quadruped_crawl_gait_generator_top.sv */
`timescale 1ns / 1ps
// crawl gait generator: each request (forward, lateral, turn speed) advances the
// gait one control tick and yields four responses, legs FR, FL, BL, BR, the last
// flagged with rsp_last_leg. the front stage takes a request, updates the phase
// counter, swing flags and leg tick counters, and queues the tick (two deep). the
// back stage turns it into offsets through one shared 17-bit restoring divider,
// one quotient bit a cycle: 12 divisions per moving tick plus one for the lift
// when a leg swings, then one response per leg; a stand-still tick needs no
// division. the input keeps accepting while the queue has room, and a finished
// response waits in an output register. registers: index 0 window_ticks,
// 1 lift_height, 2 speed_deadband; write them only while the block is idle.
module quadruped_crawl_gait_generator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [5:0]  req_forward_speed,
   input  logic signed [5:0]  req_lateral_speed,
   input  logic signed [5:0]  req_turn_speed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [$clog2(qcgg_pkg::NUM_LEGS_C)-1:0] rsp_leg_index,
   output logic signed [6:0]  rsp_offset_x,
   output logic signed [7:0]  rsp_offset_y,
   output logic signed [7:0]  rsp_offset_z,
   output logic               rsp_swinging,
   output logic               rsp_last_leg,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   // configuration registers
   logic [7:0] window_ff;
   logic [7:0] lift_ff;
   logic [4:0] deadband_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= qcgg_pkg::WINDOW_RESET;
         lift_ff     <= qcgg_pkg::LIFT_RESET;
         deadband_ff <= qcgg_pkg::DEADBAND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            qcgg_pkg::REG_WINDOW_TICKS:   window_ff   <= csr_wdata;
            qcgg_pkg::REG_LIFT_HEIGHT:    lift_ff     <= csr_wdata;
            qcgg_pkg::REG_SPEED_DEADBAND: deadband_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // tick queue between front and back
   qcgg_pkg::job_type q_mem [2];
   qcgg_pkg::job_type q_job;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       q_push, q_pop, q_full, q_empty;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, q_push} - {1'b0, q_pop};
      end
      if (q_push) begin
         q_mem[wr_ptr_ff] <= q_job;
      end
   end

   qcgg_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_forward_speed (req_forward_speed),
      .req_lateral_speed (req_lateral_speed),
      .req_turn_speed    (req_turn_speed),
      .window_ticks      (window_ff),
      .lift_height       (lift_ff),
      .speed_deadband    (deadband_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (q_job)
   );

   qcgg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_mem[rd_ptr_ff]),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_leg_index (rsp_leg_index),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_offset_z  (rsp_offset_z),
      .rsp_swinging  (rsp_swinging),
      .rsp_last_leg  (rsp_last_leg)
   );

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("tick queue overflow");

   // only the back stage pops, never from an empty queue
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty tick queue");

   // lift offset never points down
   a_lift_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_offset_z[7] || rsp_offset_z == 8'sd0))
      else $error("positive lift offset");

endmodule

/* sv/qcgg_front.sv */
`timescale 1ns / 1ps
module qcgg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [5:0]   req_forward_speed,
   input  logic signed [5:0]   req_lateral_speed,
   input  logic signed [5:0]   req_turn_speed,
   input  logic [7:0]          window_ticks,
   input  logic [7:0]          lift_height,
   input  logic [4:0]          speed_deadband,
   input  logic                q_full,
   output logic                q_push,
   output qcgg_pkg::job_type   q_job
);

   logic [9:0]      phase_ff, phase_in;
   logic [3:0]      flags_ff, flags_in;
   logic [3:0][9:0] cnt_ff, cnt_in;

   logic            stand;
   logic [7:0]      cyc;
   logic [9:0]      c;
   logic [10:0]     bound [4];
   logic [10:0]     base [4];
   logic [10:0]     half [4];
   logic [10:0]     c1, kw;
   logic [1:0]      wsel;
   logic            placed;
   logic [9:0]      cb;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign stand = (qcgg_pkg::abs6(req_forward_speed) < {1'b0, speed_deadband}) &&
                  (qcgg_pkg::abs6(req_lateral_speed) < {1'b0, speed_deadband}) &&
                  (qcgg_pkg::abs6(req_turn_speed) < {1'b0, speed_deadband});
   assign cyc = (window_ticks < qcgg_pkg::WINDOW_MIN) ? qcgg_pkg::WINDOW_MIN : window_ticks;
   assign c   = phase_ff + 10'd1;
   assign c1  = {1'b0, c};

   always_comb begin
      base[0]  = 11'd0;
      bound[0] = {3'b0, cyc};
      bound[1] = {2'b0, cyc, 1'b0};
      bound[2] = bound[0] + bound[1];
      bound[3] = {1'b0, cyc, 2'b0};
      base[1]  = bound[0];
      base[2]  = bound[1];
      base[3]  = bound[2];
      half[0]  = bound[0] >> 1;
      half[1]  = bound[2] >> 1;
      half[2]  = (bound[3] + bound[0]) >> 1;
      half[3]  = ({cyc, 3'b0} - bound[0]) >> 1;
      wsel = 2'd3;
      for (int w = 3; w >= 0; w--) begin
         if (c1 < bound[w]) begin
            wsel = 2'(w);
         end
      end
      placed = c1 < bound[3];
      kw = (c1 < half[wsel]) ? (c1 - base[wsel]) : (bound[wsel] - c1);
   end

   always_comb begin
      phase_in = phase_ff;
      flags_in = flags_ff;
      cnt_in   = cnt_ff;
      cb       = 10'd0;
      if (q_push) begin
         if (stand) begin
            phase_in = 10'd0;
            flags_in = 4'd0;
            cnt_in   = '0;
         end else begin
            phase_in = placed ? c : 10'd0;
            if (placed) begin
               flags_in = 4'd1 << qcgg_pkg::SWING_ORDER[wsel];
            end
            for (int i = 0; i < 4; i++) begin
               cb = (flags_in[i] != flags_ff[i]) ? 10'd0 : cnt_ff[i];
               cnt_in[i] = (cb == qcgg_pkg::COUNT_MAX) ? cb : cb + 10'd1;
            end
         end
      end
   end

   always_comb begin
      q_job.stand  = stand;
      q_job.fwd    = req_forward_speed;
      q_job.lat    = req_lateral_speed;
      q_job.turn   = req_turn_speed;
      q_job.cyc    = cyc;
      q_job.lift   = lift_height;
      q_job.flags  = flags_in;
      q_job.cnt    = cnt_in;
      q_job.placed = placed;
      q_job.leg    = qcgg_pkg::SWING_ORDER[wsel];
      q_job.k      = kw[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 10'd0;
         flags_ff <= 4'd0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* sv/qcgg_div.sv */
`timescale 1ns / 1ps
module qcgg_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] dividend,
   input  logic [9:0]  divisor,
   output logic        done,
   output logic [16:0] quotient
);

   logic [16:0] num_ff, num_in;
   logic [16:0] quo_ff, quo_in;
   logic [10:0] rem_ff, rem_in;
   logic [9:0]  den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [11:0] trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // restoring division, one quotient bit a cycle
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[16]};
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = 11'd0;
         quo_in  = 17'd0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[15:0], 1'b0};
         if (trial >= {2'b0, den_ff}) begin
            rem_in = 11'(trial - {2'b0, den_ff});
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial[10:0];
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

/* sv/qcgg_back.sv */
`timescale 1ns / 1ps
module qcgg_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  qcgg_pkg::job_type  q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_leg_index,
   output logic signed [6:0]  rsp_offset_x,
   output logic signed [7:0]  rsp_offset_y,
   output logic signed [7:0]  rsp_offset_z,
   output logic               rsp_swinging,
   output logic               rsp_last_leg
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_GO   = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]         st_ff, st_in;
   logic [1:0]         leg_ff, leg_in;
   logic [1:0]         term_ff, term_in;
   logic               lift_ff, lift_in;
   qcgg_pkg::job_type  job_ff, job_in;
   logic [16:0]        prod_ff, prod_in;
   logic [9:0]         den_ff, den_in;
   logic               neg_ff, neg_in;
   logic signed [19:0] acc_ff [3];
   logic signed [19:0] acc_in [3];
   logic signed [7:0]  lat_ff [4];
   logic signed [7:0]  lat_in [4];
   logic signed [7:0]  lz_ff [4];
   logic signed [7:0]  lz_in [4];

   logic               ov_ff, ov_in;
   logic [1:0]         oleg_ff, oleg_in;
   logic signed [6:0]  ox_ff, ox_in;
   logic signed [7:0]  oy_ff, oy_in;
   logic signed [7:0]  oz_ff, oz_in;
   logic               osw_ff, osw_in;

   logic               div_done;
   logic [16:0]        quo;
   logic signed [5:0]  v;
   logic [5:0]         mag;
   logic signed [19:0] sq, s20, ramp, ysum;
   logic               out_free;
   logic signed [7:0]  yv;
   logic signed [6:0]  xv;

   qcgg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (st_ff == S_GO),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign rsp_valid     = ov_ff;
   assign rsp_leg_index = oleg_ff;
   assign rsp_offset_x  = ox_ff;
   assign rsp_offset_y  = oy_ff;
   assign rsp_offset_z  = oz_ff;
   assign rsp_swinging  = osw_ff;
   assign rsp_last_leg  = (oleg_ff == 2'd3);
   assign out_free      = !ov_ff || !rsp_stall;

   always_comb begin
      case (term_ff)
         2'd0:    v = job_ff.fwd;
         2'd1:    v = job_ff.lat;
         default: v = job_ff.turn;
      endcase
      mag  = qcgg_pkg::abs6(v);
      s20  = {{13{v[5]}}, v, 1'b0};
      sq   = neg_ff ? -$signed({3'b0, quo}) : $signed({3'b0, quo});
      ramp = job_ff.flags[leg_ff] ? (sq - s20) : (s20 - sq);
      ysum = leg_ff[1] ? (acc_ff[1] - acc_ff[2]) : (acc_ff[1] + acc_ff[2]);
      if (acc_ff[0] > 20'sd63) begin
         xv = 7'sd63;
      end else if (acc_ff[0] < -20'sd64) begin
         xv = -7'sd64;
      end else begin
         xv = acc_ff[0][6:0];
      end
      if (ysum > 20'sd127) begin
         yv = 8'sd127;
      end else if (ysum < -20'sd128) begin
         yv = -8'sd128;
      end else begin
         yv = ysum[7:0];
      end
   end

   always_comb begin
      st_in   = st_ff;
      leg_in  = leg_ff;
      term_in = term_ff;
      lift_in = lift_ff;
      job_in  = job_ff;
      prod_in = prod_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      lat_in  = lat_ff;
      lz_in   = lz_ff;
      q_pop   = 1'b0;
      ov_in   = ov_ff && rsp_stall;
      oleg_in = oleg_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      oz_in   = oz_ff;
      osw_in  = osw_ff;
      case (st_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               job_in  = q_head;
               leg_in  = 2'd0;
               term_in = 2'd0;
               lift_in = q_head.placed;
               if (q_head.stand) begin
                  for (int i = 0; i < 4; i++) begin
                     lz_in[i] = 8'sd0;
                  end
                  st_in = S_EMIT;
               end else begin
                  st_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (lift_ff) begin
               prod_in = {1'b0, 16'(job_ff.k * job_ff.lift)};
               den_in  = {2'b0, job_ff.cyc};
               neg_in  = 1'b0;
            end else begin
               prod_in = 17'({7'b0, job_ff.cnt[leg_ff]} * {9'b0, mag, 2'b00});
               den_in  = job_ff.flags[leg_ff] ? {2'b0, job_ff.cyc} :
                         10'({2'b0, job_ff.cyc} + {1'b0, job_ff.cyc, 1'b0});
               neg_in  = v[5];
            end
            st_in = S_GO;
         end
         S_GO: begin
            st_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (lift_ff) begin
                  lz_in[job_ff.leg] = (quo >= 17'd128) ? -8'sd128 :
                                      $signed(8'(8'd0 - quo[7:0]));
                  lift_in = 1'b0;
                  st_in   = S_MUL;
               end else begin
                  acc_in[term_ff] = ramp;
                  if (term_ff == 2'd2) begin
                     st_in = S_EMIT;
                  end else begin
                     term_in = term_ff + 2'd1;
                     st_in   = S_MUL;
                  end
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ov_in   = 1'b1;
               oleg_in = leg_ff;
               oz_in   = lz_ff[leg_ff];
               if (job_ff.stand) begin
                  ox_in  = 7'sd0;
                  oy_in  = lat_ff[leg_ff];
                  osw_in = 1'b0;
               end else begin
                  ox_in          = xv;
                  oy_in          = yv;
                  lat_in[leg_ff] = yv;
                  osw_in         = job_ff.flags[leg_ff];
               end
               term_in = 2'd0;
               leg_in  = leg_ff + 2'd1;
               if (leg_ff == 2'd3) begin
                  st_in = S_IDLE;
               end else begin
                  st_in = job_ff.stand ? S_EMIT : S_MUL;
               end
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            lat_ff[i] <= 8'sd0;
            lz_ff[i]  <= 8'sd0;
         end
      end else begin
         st_ff  <= st_in;
         ov_ff  <= ov_in;
         lat_ff <= lat_in;
         lz_ff  <= lz_in;
      end
      leg_ff  <= leg_in;
      term_ff <= term_in;
      lift_ff <= lift_in;
      job_ff  <= job_in;
      prod_ff <= prod_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      oleg_ff <= oleg_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      oz_ff   <= oz_in;
      osw_ff  <= osw_in;
   end

endmodule
